[src/ide_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ide_pkg;
    localparam int DEPTH = 256;
    localparam int DATA_WIDTH = 32;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        CMD_PUSH_BACK  = 4'd0,
        CMD_PUSH_FRONT = 4'd1,
        CMD_POP_FRONT  = 4'd2,
        CMD_POP_BACK   = 4'd3,
        CMD_PEEK_FRONT = 4'd4,
        CMD_PEEK_BACK  = 4'd5,
        CMD_READ_AT    = 4'd6,
        CMD_INSERT_AT  = 4'd7,
        CMD_REMOVE_AT  = 4'd8,
        CMD_CLEAR      = 4'd9
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;      // latch request fields
        logic rd_src;    // read the shift source (idx-1 up, idx+1 down)
        logic wr_item;   // write item at target logical index
        logic wr_shift;  // write read data at the logical index in idx_reg
        logic step;      // advance idx_reg
        logic grab;      // capture read data as result value
        logic commit;    // update pointer and count, build result
    } ctl_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       up_done;
        logic       down_done;
        logic [1:0] err;
    } sts_t;
endpackage
`default_nettype wire

[src/ide_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ide_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [8:0]  position;
    logic signed [31:0] item_value;
    modport source (output valid, cmd, position, item_value, input ready);
    modport sink (input valid, cmd, position, item_value, output ready);
endinterface

interface ide_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_value;
    logic [1:0]  status;
    logic [8:0]  entry_count;
    logic        is_empty;
    modport source (output valid, result_value, status, entry_count, is_empty, input ready);
    modport sink (input valid, result_value, status, entry_count, is_empty, output ready);
endinterface
`default_nettype wire

[src/ide_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module ide_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/ide_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module ide_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ide_pkg::ctl_t ctl,
    output ide_pkg::sts_t      sts,
    input  wire logic [3:0]    in_cmd,
    input  wire logic [8:0]    in_position,
    input  wire logic [31:0]   in_value,
    output logic [31:0]        res_value,
    output logic [1:0]         res_status,
    output logic [8:0]         res_count
);
    import ide_pkg::*;

    cmd_t            cmd_reg;
    logic [CW-1:0]   pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [AW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg;     // logical index being shifted
    logic [31:0]     rv_reg;
    logic [1:0]      err;
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata;
    logic [CW-1:0]   ridx;

    always_comb
    begin
        err = ST_OK;
        unique case (cmd_reg)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
                if (count_reg == CW'(DEPTH)) err = ST_FULL;
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK:
                if (count_reg == '0) err = ST_RANGE;
            CMD_READ_AT, CMD_REMOVE_AT:
                if (pos_reg >= count_reg) err = ST_RANGE;
            CMD_INSERT_AT:
                if (pos_reg > count_reg) err = ST_RANGE;
                else if (count_reg == CW'(DEPTH)) err = ST_FULL;
            default: err = ST_OK;
        endcase
    end

    assign sts.cmd       = cmd_reg;
    assign sts.err       = err;
    assign sts.up_done   = (idx_reg <= pos_reg);
    assign sts.down_done = (idx_reg + CW'(1) >= count_reg);

    always_comb
    begin
        ridx = idx_reg;
        if (ctl.rd_src)
            ridx = (cmd_reg == CMD_INSERT_AT) ? idx_reg - CW'(1) : idx_reg + CW'(1);
    end
    assign raddr = front_reg + ridx[AW-1:0];

    always_comb
    begin
        we = ctl.wr_item | ctl.wr_shift;
        wdata = ctl.wr_item ? val_reg : rdata;
        if (ctl.wr_item && cmd_reg == CMD_PUSH_FRONT)
            waddr = front_reg - AW'(1);
        else if (ctl.wr_item && cmd_reg == CMD_PUSH_BACK)
            waddr = front_reg + count_reg[AW-1:0];
        else if (ctl.wr_item)
            waddr = front_reg + pos_reg[AW-1:0];
        else
            waddr = front_reg + idx_reg[AW-1:0];
    end

    ide_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (err == ST_OK)
        begin
            unique case (cmd_reg)
                CMD_PUSH_BACK, CMD_INSERT_AT: count_next = count_reg + CW'(1);
                CMD_PUSH_FRONT:
                begin
                    front_next = front_reg - AW'(1);
                    count_next = count_reg + CW'(1);
                end
                CMD_POP_FRONT:
                begin
                    front_next = front_reg + AW'(1);
                    count_next = count_reg - CW'(1);
                end
                CMD_POP_BACK, CMD_REMOVE_AT: count_next = count_reg - CW'(1);
                CMD_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            cmd_reg   <= CMD_CLEAR;
        end
        else
        begin
            if (ctl.load)
                cmd_reg <= cmd_t'(in_cmd);
            if (ctl.commit)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pos_reg <= in_position;
            val_reg <= in_value[DATA_WIDTH-1:0];
            rv_reg  <= '0;
            unique case (cmd_t'(in_cmd))
                CMD_POP_BACK, CMD_PEEK_BACK: idx_reg <= count_reg - CW'(1);
                CMD_READ_AT, CMD_REMOVE_AT: idx_reg <= in_position;
                CMD_INSERT_AT: idx_reg <= count_reg;
                default: idx_reg <= '0;
            endcase
        end
        else
        begin
            if (ctl.grab)
                rv_reg <= 32'(signed'(rdata));
            if (ctl.step)
                idx_reg <= (cmd_reg == CMD_INSERT_AT) ? idx_reg - CW'(1)
                                                      : idx_reg + CW'(1);
        end
        if (ctl.commit)
        begin
            res_value  <= (err != ST_OK) ? 32'hFFFF_FFFF : rv_reg;
            res_status <= err;
            res_count  <= count_next;
        end
    end
endmodule
`default_nettype wire

[src/ide_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module ide_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ide_pkg::ctl_t      ctl,
    input  wire ide_pkg::sts_t sts
);
    import ide_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_RDWAIT = 7'b0000100,
        S_RDGRAB = 7'b0001000,
        S_SHRD   = 7'b0010000,
        S_SHWR   = 7'b0100000,
        S_COMMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   is_ins;

    assign is_ins    = (sts.cmd == CMD_INSERT_AT);
    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    ctl.load = 1'b1;
                    state_next = S_DECODE;
                end
            S_DECODE:
            begin
                if (sts.err != ST_OK)
                    state_next = S_COMMIT;
                else
                begin
                    unique case (sts.cmd)
                        CMD_PUSH_BACK, CMD_PUSH_FRONT:
                        begin
                            ctl.wr_item = 1'b1;
                            state_next = S_COMMIT;
                        end
                        CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK,
                        CMD_READ_AT, CMD_REMOVE_AT:
                            state_next = S_RDWAIT;
                        CMD_INSERT_AT:
                            state_next = S_SHRD;
                        default:
                            state_next = S_COMMIT;
                    endcase
                end
            end
            S_RDWAIT:
            begin
                ctl.grab = 1'b1;
                state_next = (sts.cmd == CMD_REMOVE_AT) ? S_SHRD : S_COMMIT;
            end
            S_RDGRAB:
                state_next = S_COMMIT;
            S_SHRD:
            begin
                // one element moves per read/write pair
                if (is_ins ? sts.up_done : sts.down_done)
                begin
                    if (is_ins)
                        ctl.wr_item = 1'b1;
                    state_next = S_COMMIT;
                end
                else
                begin
                    ctl.rd_src = 1'b1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                ctl.wr_shift = 1'b1;
                ctl.step = 1'b1;
                state_next = S_SHRD;
            end
            S_COMMIT:
            begin
                ctl.commit = 1'b1;
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule
`default_nettype wire

[src/indexed_deque_engine_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Bounded deque of 256 signed words in a circular single-port-write RAM with
// indexed read, insert and remove. One request at a time: insert_at moves
// count-position elements and remove_at count-position-1, one element per RAM
// read/write pair. Each request gives one response held until taken.
module indexed_deque_engine_unit (
    input wire logic  clk,
    input wire logic  rst_n,
    ide_in_if.sink    in_ch,
    ide_out_if.source out_ch
);
    import ide_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic [8:0] cnt;

    ide_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .ctl(ctl), .sts(sts)
    );

    ide_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .in_cmd(in_ch.cmd), .in_position(in_ch.position),
        .in_value(in_ch.item_value),
        .res_value(out_ch.result_value), .res_status(out_ch.status),
        .res_count(cnt)
    );

    assign out_ch.entry_count = cnt;
    assign out_ch.is_empty    = (cnt == 9'd0);
endmodule
`default_nettype wire

[dv/indexed_deque_engine_unit_test.sv]
`timescale 1ns / 1ps
module indexed_deque_engine_unit_test;
    import ide_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [3:0]  cmd;
        logic [8:0]  position;
        logic [31:0] item_value;
    } deque_req_t;

    typedef struct {
        logic [31:0] result_value;
        logic [1:0]  status;
        logic [8:0]  entry_count;
        logic        is_empty;
    } deque_rsp_t;

    // directed row: request plus optional typed-in response
    typedef struct {
        deque_req_t req;
        bit         fixed;
        deque_rsp_t rsp;
    } directed_row_t;

    logic clk;
    logic rst_n;
    ide_in_if  in_ch();
    ide_out_if out_ch();

    indexed_deque_engine_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // predictor state
    logic [31:0] deque_words[DEPTH];
    logic [7:0]  head_slot;
    int          live_count;

    deque_rsp_t  pending_rsp[$];
    int          mismatch_count = 0;
    longint      cycle_count = 0;
    directed_row_t rows[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [7:0] slot_at(int idx);
        return 8'((int'(head_slot) + idx) % DEPTH);
    endfunction

    function automatic deque_rsp_t apply_deque_cmd(deque_req_t r);
        deque_rsp_t o;
        int i;
        o.result_value = '0;
        o.status = ST_OK;
        case (r.cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (live_count >= DEPTH)
                    o.status = ST_FULL;
                else if (r.cmd == CMD_PUSH_BACK)
                begin
                    deque_words[slot_at(live_count)] = r.item_value;
                    live_count++;
                end
                else
                begin
                    head_slot = head_slot - 8'd1;
                    deque_words[head_slot] = r.item_value;
                    live_count++;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT:
            begin
                if (live_count == 0)
                    o.status = ST_RANGE;
                else
                begin
                    o.result_value = deque_words[head_slot];
                    if (r.cmd == CMD_POP_FRONT)
                    begin
                        head_slot = head_slot + 8'd1;
                        live_count--;
                    end
                end
            end
            CMD_POP_BACK, CMD_PEEK_BACK:
            begin
                if (live_count == 0)
                    o.status = ST_RANGE;
                else
                begin
                    o.result_value = deque_words[slot_at(live_count - 1)];
                    if (r.cmd == CMD_POP_BACK)
                        live_count--;
                end
            end
            CMD_READ_AT:
            begin
                if (r.position >= live_count)
                    o.status = ST_RANGE;
                else
                    o.result_value = deque_words[slot_at(r.position)];
            end
            CMD_INSERT_AT:
            begin
                if (r.position > live_count)
                    o.status = ST_RANGE;
                else if (live_count >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    for (i = live_count; i > r.position; i--)
                        deque_words[slot_at(i)] = deque_words[slot_at(i - 1)];
                    deque_words[slot_at(r.position)] = r.item_value;
                    live_count++;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (r.position >= live_count)
                    o.status = ST_RANGE;
                else
                begin
                    o.result_value = deque_words[slot_at(r.position)];
                    for (i = r.position; i + 1 < live_count; i++)
                        deque_words[slot_at(i)] = deque_words[slot_at(i + 1)];
                    live_count--;
                end
            end
            CMD_CLEAR:
            begin
                live_count = 0;
                head_slot = '0;
            end
            default: ;
        endcase
        if (o.status != ST_OK)
            o.result_value = 32'hFFFF_FFFF;
        o.entry_count = 9'(live_count);
        o.is_empty = (live_count == 0);
        return o;
    endfunction

    function automatic deque_req_t mk_req(logic [3:0] c, int p, logic [31:0] v);
        deque_req_t r;
        r.cmd = c;
        r.position = 9'(p);
        r.item_value = v;
        return r;
    endfunction

    function automatic deque_rsp_t mk_rsp(logic [31:0] v, logic [1:0] s, int n);
        deque_rsp_t o;
        o.result_value = v;
        o.status = s;
        o.entry_count = 9'(n);
        o.is_empty = (n == 0);
        return o;
    endfunction

    task automatic add_row(deque_req_t r, bit fixed, deque_rsp_t o);
        directed_row_t d;
        d.req = r;
        d.fixed = fixed;
        d.rsp = o;
        rows.push_back(d);
    endtask

    // drive one request and wait for acceptance
    task automatic send_req(deque_req_t r, bit fixed, deque_rsp_t o);
        deque_rsp_t predicted;
        in_ch.valid <= 1'b1;
        in_ch.cmd <= r.cmd;
        in_ch.position <= r.position;
        in_ch.item_value <= r.item_value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = apply_deque_cmd(r);
        pending_rsp.push_back(fixed ? o : predicted);
        @(negedge clk);
    endtask

    int burst_left;

    task automatic pace_then_send(deque_req_t r, bit fixed, deque_rsp_t o);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send_req(r, fixed, o);
    endtask

    // receiver stall pattern: ready chosen at random from four mixes of ready and stall
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            case (($urandom_range(0, 3) + cycle_count / 300) % 4)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= $urandom_range(0, 1);
                default: out_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        deque_rsp_t e;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response value=%h status=%0d count=%0d",
                        out_ch.result_value, out_ch.status, out_ch.entry_count);
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (out_ch.result_value !== e.result_value || out_ch.status !== e.status
                    || out_ch.entry_count !== e.entry_count
                    || out_ch.is_empty !== e.is_empty)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                            e.result_value, e.status, e.entry_count, e.is_empty,
                            out_ch.result_value, out_ch.status, out_ch.entry_count,
                            out_ch.is_empty);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("indexed_deque_engine_unit verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // random request biased toward the target fill
    function automatic deque_req_t rand_req(int fill_goal);
        int c;
        int p;
        c = $urandom_range(0, 99);
        if (c < 2)
            return mk_req(4'($urandom_range(10, 15)), $urandom_range(0, 511), $urandom);
        if (c < 3)
            return mk_req(CMD_CLEAR, $urandom_range(0, 511), $urandom);
        // indexed positions mostly in range, some just past, a few anywhere
        case ($urandom_range(0, 9))
            0: p = live_count;
            1: p = live_count + 1;
            2: p = $urandom_range(0, 511);
            default: p = (live_count == 0) ? 0 : $urandom_range(0, live_count - 1);
        endcase
        if (p > 511)
            p = 511;
        c = $urandom_range(0, 8);
        if (c <= 1 && live_count > fill_goal && $urandom_range(0, 1))
            c += 2;
        return mk_req(4'(c), p, rand_word());
    endfunction

    initial
    begin
        deque_rsp_t none;
        int i;
        int goal;
        none = mk_rsp('0, ST_OK, 0);
        burst_left = 0;
        head_slot = '0;
        live_count = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_CLEAR;
        in_ch.position = '0;
        in_ch.item_value = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty errors, extremes, every command
        add_row(mk_req(CMD_POP_FRONT, 0, 0), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, 0));
        add_row(mk_req(CMD_POP_BACK, 0, 0), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, 0));
        add_row(mk_req(CMD_PEEK_FRONT, 0, 0), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, 0));
        add_row(mk_req(CMD_PEEK_BACK, 0, 0), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, 0));
        add_row(mk_req(CMD_READ_AT, 0, 0), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, 0));
        add_row(mk_req(CMD_REMOVE_AT, 0, 0), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, 0));
        add_row(mk_req(CMD_INSERT_AT, 1, 5), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, 0));
        add_row(mk_req(CMD_PUSH_BACK, 0, 32'h7FFF_FFFF), 1, mk_rsp(0, ST_OK, 1));
        add_row(mk_req(CMD_PUSH_FRONT, 0, 32'h8000_0000), 1, mk_rsp(0, ST_OK, 2));
        add_row(mk_req(CMD_PEEK_FRONT, 0, 0), 1, mk_rsp(32'h8000_0000, ST_OK, 2));
        add_row(mk_req(CMD_PEEK_BACK, 0, 0), 1, mk_rsp(32'h7FFF_FFFF, ST_OK, 2));
        add_row(mk_req(CMD_INSERT_AT, 1, 32'hFFFF_FFFF), 0, none);
        add_row(mk_req(CMD_INSERT_AT, 0, 32'h0000_0001), 0, none);
        add_row(mk_req(CMD_INSERT_AT, 4, 32'h5555_AAAA), 0, none);
        add_row(mk_req(CMD_INSERT_AT, 6, 0), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, 5));
        add_row(mk_req(CMD_READ_AT, 2, 0), 0, none);
        add_row(mk_req(CMD_READ_AT, 511, 0), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, 5));
        add_row(mk_req(CMD_REMOVE_AT, 5, 0), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, 5));
        add_row(mk_req(CMD_REMOVE_AT, 1, 0), 0, none);
        add_row(mk_req(CMD_POP_FRONT, 0, 0), 0, none);
        add_row(mk_req(CMD_POP_BACK, 0, 0), 0, none);
        add_row(mk_req(4'd15, 511, 32'hFFFF_FFFF), 0, none);
        add_row(mk_req(CMD_CLEAR, 0, 0), 1, mk_rsp(0, ST_OK, 0));
        foreach (rows[k])
            send_req(rows[k].req, rows[k].fixed, rows[k].rsp);

        // fill to capacity with pushes, then check full errors and wrap
        for (i = 0; i < DEPTH; i++)
            pace_then_send(mk_req($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                0, rand_word()), 0, none);
        send_req(mk_req(CMD_PUSH_BACK, 0, 1), 1, mk_rsp(32'hFFFF_FFFF, ST_FULL, DEPTH));
        send_req(mk_req(CMD_PUSH_FRONT, 0, 1), 1, mk_rsp(32'hFFFF_FFFF, ST_FULL, DEPTH));
        send_req(mk_req(CMD_INSERT_AT, 100, 1), 1, mk_rsp(32'hFFFF_FFFF, ST_FULL, DEPTH));
        send_req(mk_req(CMD_INSERT_AT, 257, 1), 1, mk_rsp(32'hFFFF_FFFF, ST_RANGE, DEPTH));
        send_req(mk_req(CMD_READ_AT, 255, 0), 0, none);
        send_req(mk_req(CMD_REMOVE_AT, 0, 0), 0, none);
        send_req(mk_req(CMD_INSERT_AT, 0, 32'h1234_5678), 0, none);
        send_req(mk_req(CMD_REMOVE_AT, 255, 0), 0, none);
        send_req(mk_req(CMD_INSERT_AT, 255, 32'h8765_4321), 0, none);
        send_req(mk_req(CMD_PUSH_BACK, 0, 0), 0, none);

        // random phases with varied target fill
        for (i = 0; i < 1150; i++)
        begin
            if (i % 150 == 0)
                goal = (i % 300 == 0) ? $urandom_range(0, 12) : $urandom_range(0, 260);
            pace_then_send(rand_req(goal), 0, none);
        end
        in_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (mismatch_count == 0)
            $display("indexed_deque_engine_unit verification clean");
        else
            $display("indexed_deque_engine_unit verification failed");
        $finish;
    end
endmodule

[files.f]
src/ide_pkg.sv
src/ide_if.sv
src/ide_ram.sv
src/ide_datapath.sv
src/ide_ctrl.sv
src/indexed_deque_engine_unit.sv
dv/indexed_deque_engine_unit_test.sv
